>>> design/rsf_pkg.sv
`default_nettype none

package rsf_pkg;

	// Default region capacity (range 1 to 4)
	localparam int MaxRegions = 4;

	// Field widths
	localparam int CodeW  = 32;
	localparam int ChainW = 8;
	localparam int NameW  = 24;
	localparam int WordW  = 57;
	localparam int CountW = 3;
	localparam int MaskW  = 4;
	localparam int CfgIdxW = 3;
	localparam int OutDataW = 8;

	// Region word layout
	localparam int WordSpanBit = 56;
	localparam int WordChainLo = 48;
	localparam int WordStartLo = 24;
	localparam int WordStopLo  = 0;

	// Residue code layout
	localparam int CodeChainLo = 24;
	localparam int CodeNameLo  = 0;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_LIMIT_ENABLE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_REGION_COUNT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_WORD_BASE    = 3'd2;

	// Result of one comparison of a residue against one region word
	typedef struct packed {
		logic span;
		logic chain_eq;
		logic start_eq;
		logic stop_eq;
	} match_t;

endpackage

`default_nettype wire

>>> design/rsf_match.sv
`default_nettype none

// Shared comparator: one region word against one residue code.
module rsf_match (
	input  wire logic [rsf_pkg::WordW-1:0] word,
	input  wire logic [rsf_pkg::CodeW-1:0] code,
	output rsf_pkg::match_t                result
);

	logic [rsf_pkg::ChainW-1:0] code_chain;
	logic [rsf_pkg::NameW-1:0]  code_name;

	assign code_chain = code[rsf_pkg::CodeChainLo +: rsf_pkg::ChainW];
	assign code_name  = code[rsf_pkg::CodeNameLo +: rsf_pkg::NameW];

	assign result.span     = word[rsf_pkg::WordSpanBit];
	assign result.chain_eq = (word[rsf_pkg::WordChainLo +: rsf_pkg::ChainW] == code_chain);
	assign result.start_eq = (word[rsf_pkg::WordStartLo +: rsf_pkg::NameW] == code_name);
	assign result.stop_eq  = (word[rsf_pkg::WordStopLo +: rsf_pkg::NameW] == code_name);

endmodule

`default_nettype wire

>>> design/region_stream_filter_unit.sv
// region_stream_filter_unit
//
// Filters a stream of residue codes against up to MAX_REGIONS regions, each
// either a start/stop span or a whole chain. One request on the slave side
// (s_tdata = residue code) yields exactly one result on the master side
// (m_tdata = included flag and mask of regions in use not yet seen).
// Registers are written through cfg_we/cfg_index/cfg_data:
// index 0 limit_enable, 1 region_count, 2.. region words.
// The user must write registers only while idle; the block does not enforce it.
// A request is taken in IDLE, CHECK tries the active region, then SCAN tries
// one region word per cycle through a single comparator, and FINISH loads the
// output register once it is free; the scan is skipped when the active region
// settles it, limiting is off or no region is in use. s_tready is high only
// while idle, so one request is in flight at a time; the scan sets the rate.
// Reset (arst_n low) clears the registers, the active region and all
// seen flags, and empties the output register.
// A stalled receiver holds m_tvalid and m_tdata; the unit can take and work
// one more request meanwhile and holds that result until the output frees.

`default_nettype none

module region_stream_filter_unit #(
	parameter int MAX_REGIONS = rsf_pkg::MaxRegions
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration write port
	input  wire logic                         cfg_we,
	input  wire logic [rsf_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [rsf_pkg::WordW-1:0]    cfg_data,
	// residue stream in
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [rsf_pkg::CodeW-1:0]    s_tdata,  // [31:0] residue_code
	// result stream out
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [rsf_pkg::OutDataW-1:0]      m_tdata   // [0] included, [4:1] unseen_mask, [7:5] zero
);

	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	// Sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CHECK  = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	// Configuration registers
	logic                       limit_enable_q;
	logic [rsf_pkg::CountW-1:0] region_count_q;
	logic [rsf_pkg::WordW-1:0]  region_word_q [MAX_REGIONS];

	// Filter state
	logic                   active_valid_q;
	logic [IDX_W-1:0]       active_index_q;
	logic [MAX_REGIONS-1:0] seen_q;

	// Sequencer
	logic [1:0]               state_q;
	logic [rsf_pkg::CodeW-1:0] code_q;
	logic [IDX_W-1:0]         scan_idx_q;
	logic                     included_q;

	// Output register
	logic                         out_valid_q;
	logic                         out_included_q;
	logic [rsf_pkg::MaskW-1:0]    out_mask_q;

	logic [CNT_W-1:0]          used_n;
	logic [IDX_W-1:0]          sel_idx;
	logic [rsf_pkg::WordW-1:0] sel_word;
	rsf_pkg::match_t           cmp;
	logic                      active_in_use;
	logic                      scan_last;
	logic                      out_free;
	logic                      out_load;
	logic [rsf_pkg::MaskW-1:0] unseen_mask;

	// Clamp the region count to the capacity
	assign used_n = (region_count_q > rsf_pkg::CountW'(MAX_REGIONS))
		? CNT_W'(MAX_REGIONS) : CNT_W'(region_count_q);

	// The comparator looks at the active region while checking, else the scan slot
	assign sel_idx  = (state_q == ST_CHECK) ? active_index_q : scan_idx_q;
	assign sel_word = region_word_q[sel_idx];

	rsf_match u_match (
		.word   (sel_word),
		.code   (code_q),
		.result (cmp)
	);

	assign active_in_use = active_valid_q && (CNT_W'(active_index_q) < used_n);
	assign scan_last     = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == used_n);
	assign out_free      = !out_valid_q || m_tready;
	assign out_load      = (state_q == ST_FINISH) && out_free;

	always_comb begin
		unseen_mask = '0;
		for (int i = 0; i < MAX_REGIONS; i++) begin
			if ((CNT_W'(i) < used_n) && !seen_q[i]) begin
				unseen_mask[i] = 1'b1;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(rsf_pkg::OutDataW - rsf_pkg::MaskW - 1){1'b0}}, out_mask_q, out_included_q};

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_enable_q <= 1'b0;
			region_count_q <= '0;
			for (int k = 0; k < MAX_REGIONS; k++) begin
				region_word_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == rsf_pkg::REG_LIMIT_ENABLE) begin
				limit_enable_q <= cfg_data[0];
			end
			if (cfg_index == rsf_pkg::REG_REGION_COUNT) begin
				region_count_q <= cfg_data[rsf_pkg::CountW-1:0];
			end
			for (int k = 0; k < MAX_REGIONS; k++) begin
				if (cfg_index == rsf_pkg::REG_WORD_BASE + rsf_pkg::CfgIdxW'(k)) begin
					region_word_q[k] <= cfg_data;
				end
			end
		end
	end

	// Request payload, held while the sequencer works on it
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_q <= s_tdata;
		end
	end

	// Sequencer: check the active region, then scan regions with the shared comparator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			active_valid_q <= 1'b0;
			active_index_q <= '0;
			seen_q         <= '0;
			scan_idx_q     <= '0;
			included_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			out_included_q <= 1'b0;
			out_mask_q     <= '0;
		end else begin
			// Load a finished result, else drop it once the receiver takes it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end

				ST_CHECK: begin
					scan_idx_q <= '0;
					if (!limit_enable_q) begin
						// Pass everything, state untouched
						included_q <= 1'b1;
						state_q    <= ST_FINISH;
					end else if (active_in_use && cmp.span) begin
						// Inside an open span; close it on its stop residue
						included_q <= 1'b1;
						if (cmp.chain_eq && cmp.stop_eq) begin
							active_valid_q <= 1'b0;
						end
						state_q <= ST_FINISH;
					end else if (active_in_use && cmp.chain_eq) begin
						// Still on the active whole chain
						included_q <= 1'b1;
						state_q    <= ST_FINISH;
					end else begin
						// Active region gone or left: release it and scan
						active_valid_q <= 1'b0;
						included_q     <= 1'b0;
						state_q        <= (used_n == '0) ? ST_FINISH : ST_SCAN;
					end
				end

				ST_SCAN: begin
					if (cmp.chain_eq && (!cmp.span || cmp.start_eq)) begin
						// First match wins; a span that opens and closes at once stays inactive
						included_q          <= 1'b1;
						seen_q[scan_idx_q]  <= 1'b1;
						if (!(cmp.span && cmp.stop_eq)) begin
							active_valid_q <= 1'b1;
							active_index_q <= scan_idx_q;
						end
						state_q <= ST_FINISH;
					end else if (scan_last) begin
						state_q <= ST_FINISH;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end

				ST_FINISH: begin
					// Hold until the output register is free
					if (out_free) begin
						out_included_q <= included_q;
						out_mask_q     <= limit_enable_q ? unseen_mask : '0;
						state_q        <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rsf_pkg::*;

	// Register indexes the block does not decode; writes there must be ignored
	localparam logic [CfgIdxW-1:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_UNMAPPED_B = 3'd7;

	localparam int NumWords    = 4;
	localparam int PhaseItems  = 70;
	localparam int NumPhases   = 12;
	localparam int QuietLimit  = 2000;
	localparam int TailCycles  = 20;

	typedef struct packed {
		logic               inc;
		logic [MaskW-1:0]   mask;
	} verdict_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

	typedef struct {
		row_kind_e            kind;
		logic [CfgIdxW-1:0]   idx;
		logic [WordW-1:0]     data;   // residue code in the low bits for an item row
		bit                   typed;
		verdict_t             want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CfgIdxW-1:0]   cfg_index = '0;
	logic [WordW-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [CodeW-1:0]     s_tdata = '0;    // [31:0] residue_code
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OutDataW-1:0]  m_tdata;         // [0] included, [4:1] unseen_mask, [7:5] zero

	// Mirror of the block's registers and filter state
	logic                 cfg_limit = 1'b0;
	logic [CountW-1:0]    cfg_count = '0;
	logic [WordW-1:0]     cfg_word [NumWords] = '{default: '0};
	logic                 span_open = 1'b0;
	logic [1:0]           open_idx = '0;
	logic [NumWords-1:0]  visited = '0;

	verdict_t             pending_verdicts [$];
	plan_row_t            plan [$];
	int                   failures = 0;
	int                   stall_pct = 0;
	int                   gap_pct = 0;
	bit                   calm = 1'b0;
	int unsigned          quiet_cycles = 0;

	region_stream_filter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [WordW-1:0] region_word(bit span, logic [ChainW-1:0] chain,
			logic [NameW-1:0] start, logic [NameW-1:0] stop);
		return {span, chain, start, stop};
	endfunction

	function automatic logic [WordW-1:0] noise57();
		return WordW'({$urandom, $urandom});
	endfunction

	// Advance the filter state by one residue and return what the block must answer.
	function automatic verdict_t filter_residue(logic [CodeW-1:0] code);
		logic [ChainW-1:0] chain;
		logic [NameW-1:0]  name;
		logic [WordW-1:0]  w;
		int                n;
		bit                hit;
		verdict_t          v;
		chain = code[CodeChainLo +: ChainW];
		name  = code[CodeNameLo +: NameW];
		v = '0;
		// limiting off: everything passes and the state stays put
		if (!cfg_limit) begin
			v.inc = 1'b1;
			return v;
		end
		n = (cfg_count > NumWords) ? NumWords : int'(cfg_count);
		hit = 1'b0;
		// active region first, but only while its index is still in use
		if (span_open && open_idx < n) begin
			w = cfg_word[open_idx];
			if (w[WordSpanBit]) begin
				if (chain == w[WordChainLo +: ChainW] && name == w[WordStopLo +: NameW])
					span_open = 1'b0;
				hit = 1'b1;
			end else if (chain == w[WordChainLo +: ChainW]) begin
				hit = 1'b1;
			end
		end
		if (!hit) begin
			span_open = 1'b0;
			// first region in use that matches wins
			for (int i = 0; i < n && !hit; i++) begin
				w = cfg_word[i];
				if (chain == w[WordChainLo +: ChainW]) begin
					if (!w[WordSpanBit]) begin
						span_open = 1'b1;
						open_idx = 2'(i);
						visited[i] = 1'b1;
						hit = 1'b1;
					end else if (name == w[WordStartLo +: NameW]) begin
						// a one-residue span is seen but never opened
						if (name != w[WordStopLo +: NameW]) begin
							span_open = 1'b1;
							open_idx = 2'(i);
						end
						visited[i] = 1'b1;
						hit = 1'b1;
					end
				end
			end
		end
		v.inc = hit;
		for (int i = 0; i < n; i++)
			v.mask[i] = !visited[i];
		return v;
	endfunction

	// Residue drawn from the configured regions most of the time, so spans open and close.
	function automatic logic [CodeW-1:0] pick_residue();
		logic [WordW-1:0] w;
		int               k;
		w = cfg_word[$urandom_range(0, NumWords - 1)];
		k = $urandom_range(0, 99);
		if (k < 30)
			return {w[WordChainLo +: ChainW], w[WordStartLo +: NameW]};
		else if (k < 55)
			return {w[WordChainLo +: ChainW], w[WordStopLo +: NameW]};
		else if (k < 85)
			return {w[WordChainLo +: ChainW], NameW'($urandom)};
		return $urandom;
	endfunction

	function automatic logic [ChainW-1:0] pick_chain();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h5A;
			3: return 8'hA5;
			default: return ChainW'($urandom);
		endcase
	endfunction

	task automatic add_write(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
		plan.push_back('{ROW_WRITE, idx, data, 1'b0, '0});
	endtask

	task automatic add_item(logic [CodeW-1:0] code);
		plan.push_back('{ROW_ITEM, '0, WordW'(code), 1'b0, '0});
	endtask

	task automatic add_checked(logic [CodeW-1:0] code, logic inc, logic [MaskW-1:0] mask);
		plan.push_back('{ROW_ITEM, '0, WordW'(code), 1'b1, '{inc, mask}});
	endtask

	// Drop the request, then hold until every result is back so the block is idle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		s_tdata <= $urandom;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Keep cfg_we high on return; the next request lowers it.
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_LIMIT_ENABLE)
			cfg_limit = data[0];
		else if (idx == REG_REGION_COUNT)
			cfg_count = data[CountW-1:0];
		else if (idx >= REG_WORD_BASE && idx < REG_WORD_BASE + NumWords)
			cfg_word[idx - REG_WORD_BASE] = data;
	endtask

	// Present one request, wait for the handshake, queue its expected result.
	task automatic send_residue(logic [CodeW-1:0] code, bit typed, verdict_t typed_want);
		verdict_t predicted;
		cfg_we <= 1'b0;
		s_tvalid <= 1'b1;
		s_tdata <= code;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = filter_residue(code);
		pending_verdicts.push_back(typed ? typed_want : predicted);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Receiver: stall in random bursts, never in the calm stretch at the end.
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin : check_result
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with nothing expected: m_tdata %h", m_tdata);
				failures++;
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[0] !== want.inc) begin
					$error("included: expected %0d, got %0d", want.inc, m_tdata[0]);
					failures++;
				end
				if (m_tdata[1 +: MaskW] !== want.mask) begin
					$error("unseen_mask: expected %b, got %b", want.mask, m_tdata[1 +: MaskW]);
					failures++;
				end
				if (m_tdata[OutDataW-1:1+MaskW] !== '0) begin
					$error("pad: expected 0, got %b", m_tdata[OutDataW-1:1+MaskW]);
					failures++;
				end
			end
		end
	end

	// Watchdog: end the run when no handshake happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QuietLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [WordW-1:0]    w;
		logic [ChainW-1:0]   chain;
		logic [NameW-1:0]    start;
		logic [CountW-1:0]   count;
		logic                lim;
		int                  k;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Limiting is off after reset: all pass, mask zero.
		add_checked(32'h0000_0000, 1'b1, 4'b0000);
		add_checked(32'hFFFF_FFFF, 1'b1, 4'b0000);
		add_write(REG_WORD_BASE + 3'd0, region_word(1'b1, 8'h01, 24'h000010, 24'h000020));
		add_write(REG_WORD_BASE + 3'd1, region_word(1'b0, 8'h02, 24'hFFFFFF, 24'h000000));
		add_write(REG_WORD_BASE + 3'd2, region_word(1'b1, 8'hFF, 24'hFFFFFF, 24'hFFFFFF));
		add_write(REG_WORD_BASE + 3'd3, region_word(1'b1, 8'h00, 24'h000000, 24'h000005));
		add_write(REG_REGION_COUNT, WordW'(4));
		add_write(REG_LIMIT_ENABLE, WordW'(1));
		add_checked(32'h0100_0005, 1'b0, 4'b1111);   // right chain, not the start
		add_checked(32'h0100_0010, 1'b1, 4'b1110);   // span opens
		add_checked(32'h0300_0000, 1'b1, 4'b1110);   // open span takes any chain
		add_checked(32'h0100_0020, 1'b1, 4'b1110);   // stop closes the span
		add_checked(32'h0100_0021, 1'b0, 4'b1110);
		add_checked(32'h0212_3456, 1'b1, 4'b1100);   // whole chain opens
		// chain changes: whole chain closes, start equal to stop is seen, not opened
		add_checked(32'hFFFF_FFFF, 1'b1, 4'b1000);
		add_checked(32'hFF00_0001, 1'b0, 4'b1000);
		add_checked(32'h0200_0000, 1'b1, 4'b1000);
		// active whole chain falls out of use and is dropped
		add_write(REG_REGION_COUNT, WordW'(1));
		add_checked(32'h0200_0001, 1'b0, 4'b0000);
		// count above the capacity clamps to four
		add_write(REG_REGION_COUNT, WordW'(7));
		add_checked(32'h0100_0010, 1'b1, 4'b1000);
		add_write(REG_UNMAPPED_A, noise57());
		add_write(REG_UNMAPPED_B, noise57());
		add_item(32'h0100_0011);
		// limiting off leaves the open span alone
		add_write(REG_LIMIT_ENABLE, WordW'(0));
		add_checked(32'h0000_0005, 1'b1, 4'b0000);
		add_write(REG_LIMIT_ENABLE, WordW'(1));
		add_checked(32'h0100_0020, 1'b1, 4'b1000);
		add_write(REG_REGION_COUNT, WordW'(0));
		add_checked(32'h0200_0000, 1'b0, 4'b0000);

		stall_pct = 20;
		gap_pct = 20;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_residue(plan[i].data[CodeW-1:0], plan[i].typed, plan[i].want);
			end
		end

		// Random part: reconfigure at each phase boundary, then stream residues.
		for (int phase = 0; phase < NumPhases; phase++) begin
			case (phase % 4)
				0: begin stall_pct = 0;  gap_pct = 0;  end
				1: begin stall_pct = 10; gap_pct = 10; end
				2: begin stall_pct = 30; gap_pct = 30; end
				default: begin stall_pct = 60; gap_pct = 60; end
			endcase
			calm = (phase == NumPhases - 1);
			wait_drained();
			for (int r = 0; r < NumWords; r++) begin
				if ($urandom_range(0, 9) == 0) begin
					w = noise57();
				end else begin
					chain = pick_chain();
					start = NameW'($urandom);
					w = region_word(1'($urandom), chain, start,
						($urandom_range(0, 5) == 0) ? start : NameW'($urandom));
				end
				write_reg(REG_WORD_BASE + 3'(r), w);
			end
			k = $urandom_range(0, 9);
			if (phase == 0)
				count = 3'd4;
			else if (phase == NumPhases - 1 || k == 1)
				count = 3'($urandom_range(5, 7));
			else if (k == 0)
				count = 3'd0;
			else
				count = 3'($urandom_range(1, 4));
			lim = (phase == 0) ? 1'b1 : ($urandom_range(0, 7) != 0);
			// upper bits of the narrow registers carry noise half the time
			w = $urandom_range(0, 1) ? noise57() : '0;
			w[CountW-1:0] = count;
			write_reg(REG_REGION_COUNT, w);
			w = $urandom_range(0, 1) ? noise57() : '0;
			w[0] = lim;
			write_reg(REG_LIMIT_ENABLE, w);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, noise57());
			repeat (PhaseItems)
				send_residue(pick_residue(), 1'b0, '0);
		end

		wait_drained();
		repeat (TailCycles) @(posedge clk);
		if (failures == 0 && pending_verdicts.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
design/rsf_pkg.sv
design/rsf_match.sv
design/region_stream_filter_unit.sv
tb/testbench.sv
